// ----- sv/rtf3d_pkg.sv -----
// Package for the 3D tensor frame rotation block: types, codes and fixed-point helpers.
package rtf3d_pkg;

    localparam int VW = 48;
    localparam int FB = 32;
    localparam int LW = VW / 2;
    localparam int HW = VW - LW;
    localparam int AW = VW + 4;
    localparam int PW = 2 * VW;

    localparam logic [2:0] MODE_INC         = 3'd0;
    localparam logic [2:0] MODE_AXES        = 3'd1;
    localparam logic [2:0] MODE_STRAIN_FWD  = 3'd2;
    localparam logic [2:0] MODE_STRAIN_BACK = 3'd3;
    localparam logic [2:0] MODE_STRESS_FWD  = 3'd4;
    localparam logic [2:0] MODE_STRESS_BACK = 3'd5;
    localparam logic [2:0] MODE_GRAD_FWD    = 3'd6;
    localparam logic [2:0] MODE_GRAD_BACK   = 3'd7;

    typedef logic [VW-1:0] t_val;

    localparam t_val VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    localparam int VOIGT_I [6] = '{0, 1, 2, 0, 0, 1};
    localparam int VOIGT_J [6] = '{0, 1, 2, 1, 2, 2};

    // operand pairs of the third-axis cross product
    localparam int CROSS_A [6] = '{1, 4, 2, 5, 0, 3};
    localparam int CROSS_B [6] = '{5, 2, 3, 0, 4, 1};

    typedef struct packed {
        logic [2:0]             mode;
        logic signed [VW-1:0]   value_0;
        logic signed [VW-1:0]   value_1;
        logic signed [VW-1:0]   value_2;
        logic signed [VW-1:0]   value_3;
        logic signed [VW-1:0]   value_4;
        logic signed [VW-1:0]   value_5;
        logic signed [VW-1:0]   value_6;
        logic signed [VW-1:0]   value_7;
        logic signed [VW-1:0]   value_8;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0]   result_0;
        logic signed [VW-1:0]   result_1;
        logic signed [VW-1:0]   result_2;
        logic signed [VW-1:0]   result_3;
        logic signed [VW-1:0]   result_4;
        logic signed [VW-1:0]   result_5;
        logic signed [VW-1:0]   result_6;
        logic signed [VW-1:0]   result_7;
        logic signed [VW-1:0]   result_8;
        logic                   saturated;
    } t_out;

    // partial products of one split multiply
    typedef struct packed {
        logic [2*LW-1:0]        ll;
        logic signed [VW:0]     lh;
        logic signed [VW:0]     hl;
        logic signed [2*HW-1:0] hh;
    } t_pp;

    typedef struct packed {
        logic ovf;
        t_val val;
    } t_qv;

    function automatic logic signed [AW-1:0] sext(input t_val v);
        return AW'($signed(v));
    endfunction

    function automatic t_qv sat_acc(input logic signed [AW-1:0] v);
        t_qv r;
        r.ovf = (v[AW-1:VW-1] != {(AW-VW+1){v[VW-1]}});
        r.val = r.ovf ? (v[AW-1] ? VAL_MIN : VAL_MAX) : v[VW-1:0];
        return r;
    endfunction

    function automatic t_pp qmul_pp(input t_val a, input t_val b);
        t_pp r;
        r.ll = a[LW-1:0] * b[LW-1:0];
        r.lh = $signed({1'b0, a[LW-1:0]}) * $signed(b[VW-1:LW]);
        r.hl = $signed(a[VW-1:LW]) * $signed({1'b0, b[LW-1:0]});
        r.hh = $signed(a[VW-1:LW]) * $signed(b[VW-1:LW]);
        return r;
    endfunction

    // recombine, shift out the fraction (floor), saturate
    function automatic t_qv qmul_fin(input t_pp p);
        logic signed [PW-1:0] f;
        logic signed [PW-1:0] s;
        t_qv r;
        f = (PW'($signed(p.hh)) <<< (2*LW))
          + ((PW'($signed(p.lh)) + PW'($signed(p.hl))) <<< LW)
          + PW'(p.ll);
        s = f >>> FB;
        r.ovf = (s[PW-1:VW-1] != {(PW-VW+1){s[VW-1]}});
        r.val = r.ovf ? (s[PW-1] ? VAL_MIN : VAL_MAX) : s[VW-1:0];
        return r;
    endfunction

endpackage

// ----- sv/rotate_tensor_frame_3d.sv -----
// Top level of the 3D tensor frame rotation pipeline.
//
//  channel | valid   | stall   | item
//  --------+---------+---------+----------------------------
//  input   | i_valid | o_stall | i_data (rtf3d_pkg::t_in)
//  output  | o_valid | i_stall | o_data (rtf3d_pkg::t_out)
//
// One item per cycle unless a stall holds the flow; a rotation result passes through
// the stage registers into the output register (seven compute stages, each holding
// one split multiply half, a saturating add or a three-way sum).
// An axes load holds o_stall high until the new frame is written.
// An increment load is stored at acceptance and gives no result.
// Reset is synchronous and clears valids, increment and frame.
// Each stage advances when it is empty or the stage after it advances.
module rotate_tensor_frame_3d (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rtf3d_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output rtf3d_pkg::t_out   o_data
);

    rtf3d_pkg::t_val  r_inc [9];
    rtf3d_pkg::t_val  r_frame [9];
    logic [8:1]       r_v;
    logic [2:0]       r_mode [1:6];

    rtf3d_pkg::t_val  r_s1_x [9];
    rtf3d_pkg::t_val  r_s2_x [9];
    rtf3d_pkg::t_val  r_s3_x [9];
    rtf3d_pkg::t_val  r_s4_x [9];
    rtf3d_pkg::t_pp   r_s2_pp [81];
    rtf3d_pkg::t_val  r_s3_p [81];
    logic [80:0]      r_s3_pf;
    rtf3d_pkg::t_val  r_s4_c [81];
    logic             r_s4_cf;
    rtf3d_pkg::t_pp   r_s5_pp [81];
    logic             r_s5_cf;
    rtf3d_pkg::t_val  r_s6_d [81];
    logic             r_s6_f;
    logic signed [rtf3d_pkg::AW-1:0] r_s7_g [27];
    logic             r_s7_f;
    rtf3d_pkg::t_out  r_out;

    rtf3d_pkg::t_pp   r_s2_lpp [18];
    rtf3d_pkg::t_val  r_s3_lq [18];
    rtf3d_pkg::t_val  r_s4_a [6];
    rtf3d_pkg::t_pp   r_s5_xpp [6];
    rtf3d_pkg::t_val  r_s5_a [6];
    rtf3d_pkg::t_val  r_s6_xq [6];
    rtf3d_pkg::t_val  r_s6_a [6];

    rtf3d_pkg::t_pp   n_pp [81];
    rtf3d_pkg::t_pp   n_lpp [18];
    rtf3d_pkg::t_val  n_p [81];
    logic [80:0]      n_pf;
    rtf3d_pkg::t_val  n_lq [18];
    rtf3d_pkg::t_val  n_c [81];
    logic             n_cf;
    rtf3d_pkg::t_val  n_a [6];
    rtf3d_pkg::t_pp   n_dpp [81];
    rtf3d_pkg::t_pp   n_xpp [6];
    rtf3d_pkg::t_val  n_d [81];
    logic             n_df;
    rtf3d_pkg::t_val  n_xq [6];
    logic signed [rtf3d_pkg::AW-1:0] n_g [27];
    rtf3d_pkg::t_val  n_frame [9];
    rtf3d_pkg::t_out  n_out;

    logic [8:1]       w_en;
    logic             w_axes_busy;
    logic             w_in_acc;
    logic             w_frame_we;

    always_comb begin
        w_en[8] = !r_v[8] || !i_stall;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        w_axes_busy = 1'b0;
        for (int k = 1; k <= 6; k++) begin
            w_axes_busy = w_axes_busy || (r_v[k] && r_mode[k] == rtf3d_pkg::MODE_AXES);
        end
    end

    assign o_stall    = !w_en[1] || w_axes_busy;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_frame_we = r_v[6] && r_mode[6] == rtf3d_pkg::MODE_AXES && w_en[6];
    assign o_valid    = r_v[8];
    assign o_data     = r_out;

    // stage 1: frame orientation and first multiply half
    always_comb begin
        logic back;
        rtf3d_pkg::t_val u [3][3];
        back = r_mode[1] == rtf3d_pkg::MODE_STRAIN_BACK
            || r_mode[1] == rtf3d_pkg::MODE_STRESS_BACK
            || r_mode[1] == rtf3d_pkg::MODE_GRAD_BACK;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                u[i][k] = back ? r_frame[3*k+i] : r_frame[3*i+k];
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int l = 0; l < 3; l++) begin
                        n_pp[27*i+9*j+3*k+l] = rtf3d_pkg::qmul_pp(u[i][k], u[j][l]);
                    end
                end
            end
        end
        for (int n = 0; n < 2; n++) begin
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    n_lpp[9*n+3*k+m] = rtf3d_pkg::qmul_pp(r_inc[3*m+k], r_s1_x[3*n+m]);
                end
            end
        end
    end

    // stage 2: finish frame and increment products
    always_comb begin
        rtf3d_pkg::t_qv q;
        for (int t = 0; t < 81; t++) begin
            q = rtf3d_pkg::qmul_fin(r_s2_pp[t]);
            n_p[t]  = q.val;
            n_pf[t] = q.ovf;
        end
        for (int t = 0; t < 18; t++) begin
            q = rtf3d_pkg::qmul_fin(r_s2_lpp[t]);
            n_lq[t] = q.val;
        end
    end

    // stage 3: rotation coefficients; rotated axes
    always_comb begin
        logic full;
        logic strain;
        int i;
        int j;
        int k;
        int l;
        int pa;
        int pb;
        rtf3d_pkg::t_qv q;
        i  = 0;
        j  = 0;
        k  = 0;
        l  = 0;
        pa = 0;
        pb = 0;
        q  = '0;
        full = r_mode[3] == rtf3d_pkg::MODE_GRAD_FWD || r_mode[3] == rtf3d_pkg::MODE_GRAD_BACK;
        strain = r_mode[3] == rtf3d_pkg::MODE_STRAIN_FWD
              || r_mode[3] == rtf3d_pkg::MODE_STRAIN_BACK;
        n_cf = 1'b0;
        for (int rr = 0; rr < 9; rr++) begin
            for (int ss = 0; ss < 9; ss++) begin
                n_c[9*rr+ss] = '0;
                if (full) begin
                    n_c[9*rr+ss] = r_s3_p[9*rr+ss];
                    n_cf = n_cf | r_s3_pf[9*rr+ss];
                end else if (rr < 6 && ss < 6) begin
                    i  = rtf3d_pkg::VOIGT_I[rr];
                    j  = rtf3d_pkg::VOIGT_J[rr];
                    k  = rtf3d_pkg::VOIGT_I[ss];
                    l  = rtf3d_pkg::VOIGT_J[ss];
                    pa = 27*i + 9*j + 3*k + l;
                    pb = 27*i + 9*j + 3*l + k;
                    if (k == l) begin
                        if (strain && i != j) begin
                            q = rtf3d_pkg::sat_acc(rtf3d_pkg::sext(r_s3_p[pa])
                                + rtf3d_pkg::sext(r_s3_p[pa]));
                            n_c[9*rr+ss] = q.val;
                            n_cf = n_cf | r_s3_pf[pa] | q.ovf;
                        end else begin
                            n_c[9*rr+ss] = r_s3_p[pa];
                            n_cf = n_cf | r_s3_pf[pa];
                        end
                    end else if (strain && i == j) begin
                        n_c[9*rr+ss] = r_s3_p[pa];
                        n_cf = n_cf | r_s3_pf[pa];
                    end else begin
                        q = rtf3d_pkg::sat_acc(rtf3d_pkg::sext(r_s3_p[pa])
                            + rtf3d_pkg::sext(r_s3_p[pb]));
                        n_c[9*rr+ss] = q.val;
                        n_cf = n_cf | r_s3_pf[pa] | r_s3_pf[pb] | q.ovf;
                    end
                end
            end
        end
        for (int t = 0; t < 6; t++) begin
            q = rtf3d_pkg::sat_acc(rtf3d_pkg::sext(r_s3_lq[3*t])
                + rtf3d_pkg::sext(r_s3_lq[3*t+1]) + rtf3d_pkg::sext(r_s3_lq[3*t+2]));
            n_a[t] = q.val;
        end
    end

    // stage 4: first half of data and cross products
    always_comb begin
        for (int t = 0; t < 81; t++) begin
            n_dpp[t] = rtf3d_pkg::qmul_pp(r_s4_c[t], r_s4_x[t % 9]);
        end
        for (int t = 0; t < 6; t++) begin
            n_xpp[t] = rtf3d_pkg::qmul_pp(r_s4_a[rtf3d_pkg::CROSS_A[t]],
                                          r_s4_a[rtf3d_pkg::CROSS_B[t]]);
        end
    end

    // stage 5: finish data and cross products
    always_comb begin
        rtf3d_pkg::t_qv q;
        n_df = r_s5_cf;
        for (int t = 0; t < 81; t++) begin
            q = rtf3d_pkg::qmul_fin(r_s5_pp[t]);
            n_d[t] = q.val;
            n_df = n_df | q.ovf;
        end
        for (int t = 0; t < 6; t++) begin
            q = rtf3d_pkg::qmul_fin(r_s5_xpp[t]);
            n_xq[t] = q.val;
        end
    end

    // stage 6: partial row sums; new frame
    always_comb begin
        rtf3d_pkg::t_qv q;
        for (int t = 0; t < 27; t++) begin
            n_g[t] = rtf3d_pkg::sext(r_s6_d[3*t]) + rtf3d_pkg::sext(r_s6_d[3*t+1])
                   + rtf3d_pkg::sext(r_s6_d[3*t+2]);
        end
        for (int t = 0; t < 6; t++) begin
            n_frame[t] = r_s6_a[t];
        end
        for (int t = 0; t < 3; t++) begin
            q = rtf3d_pkg::sat_acc(rtf3d_pkg::sext(r_s6_xq[2*t])
                - rtf3d_pkg::sext(r_s6_xq[2*t+1]));
            n_frame[6+t] = q.val;
        end
    end

    // stage 7: final row sums
    always_comb begin
        rtf3d_pkg::t_qv q;
        rtf3d_pkg::t_val res [9];
        logic sat;
        sat = r_s7_f;
        for (int r = 0; r < 9; r++) begin
            q = rtf3d_pkg::sat_acc(r_s7_g[3*r] + r_s7_g[3*r+1] + r_s7_g[3*r+2]);
            res[r] = q.val;
            sat = sat | q.ovf;
        end
        n_out.result_0  = res[0];
        n_out.result_1  = res[1];
        n_out.result_2  = res[2];
        n_out.result_3  = res[3];
        n_out.result_4  = res[4];
        n_out.result_5  = res[5];
        n_out.result_6  = res[6];
        n_out.result_7  = res[7];
        n_out.result_8  = res[8];
        n_out.saturated = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_inc   <= '{default: '0};
            r_frame <= '{default: '0};
        end else begin
            if (w_in_acc && i_data.mode == rtf3d_pkg::MODE_INC) begin
                r_inc[0] <= i_data.value_0;
                r_inc[1] <= i_data.value_1;
                r_inc[2] <= i_data.value_2;
                r_inc[3] <= i_data.value_3;
                r_inc[4] <= i_data.value_4;
                r_inc[5] <= i_data.value_5;
                r_inc[6] <= i_data.value_6;
                r_inc[7] <= i_data.value_7;
                r_inc[8] <= i_data.value_8;
            end
            if (w_frame_we) begin
                r_frame <= n_frame;
            end
            if (w_en[1]) begin
                r_v[1] <= w_in_acc && i_data.mode != rtf3d_pkg::MODE_INC;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_en[7]) begin
                r_v[7] <= r_v[6] && r_mode[6] != rtf3d_pkg::MODE_AXES;
            end
            if (w_en[8]) begin
                r_v[8] <= r_v[7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_mode[1] <= i_data.mode;
            r_s1_x[0] <= i_data.value_0;
            r_s1_x[1] <= i_data.value_1;
            r_s1_x[2] <= i_data.value_2;
            r_s1_x[3] <= i_data.value_3;
            r_s1_x[4] <= i_data.value_4;
            r_s1_x[5] <= i_data.value_5;
            r_s1_x[6] <= i_data.value_6;
            r_s1_x[7] <= i_data.value_7;
            r_s1_x[8] <= i_data.value_8;
        end
        if (w_en[2]) begin
            r_mode[2] <= r_mode[1];
            r_s2_x    <= r_s1_x;
            r_s2_pp   <= n_pp;
            r_s2_lpp  <= n_lpp;
        end
        if (w_en[3]) begin
            r_mode[3] <= r_mode[2];
            r_s3_x    <= r_s2_x;
            r_s3_p    <= n_p;
            r_s3_pf   <= n_pf;
            r_s3_lq   <= n_lq;
        end
        if (w_en[4]) begin
            r_mode[4] <= r_mode[3];
            r_s4_x    <= r_s3_x;
            r_s4_c    <= n_c;
            r_s4_cf   <= n_cf;
            r_s4_a    <= n_a;
        end
        if (w_en[5]) begin
            r_mode[5] <= r_mode[4];
            r_s5_pp   <= n_dpp;
            r_s5_cf   <= r_s4_cf;
            r_s5_xpp  <= n_xpp;
            r_s5_a    <= r_s4_a;
        end
        if (w_en[6]) begin
            r_mode[6] <= r_mode[5];
            r_s6_d    <= n_d;
            r_s6_f    <= n_df;
            r_s6_xq   <= n_xq;
            r_s6_a    <= r_s5_a;
        end
        if (w_en[7]) begin
            r_s7_g    <= n_g;
            r_s7_f    <= r_s6_f;
        end
        if (w_en[8]) begin
            r_out     <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // a new frame is written only with nothing queued behind the load
    a_frame_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame_we |-> (r_v[5:1] == '0))
        else $error("frame written with items behind the load");

    // an accepted axes load blocks the input on the next cycle
    a_axes_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.mode == rtf3d_pkg::MODE_AXES) |=> o_stall)
        else $error("input open while axes load in flight");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

// ----- sim/rotate_tensor_frame_3d_tb.sv -----
// Self-checking testbench for the 3D tensor frame rotation block.
module rotate_tensor_frame_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;
    typedef struct {
        rtf3d_pkg::t_in  d;
        bit              typed;
        rtf3d_pkg::t_out want;
    } t_row;
    localparam t_wide WMAX = (t_wide'(1) <<< (rtf3d_pkg::VW - 1)) - 1;
    localparam t_wide WMIN = -(t_wide'(1) <<< (rtf3d_pkg::VW - 1));
    localparam rtf3d_pkg::t_val ONE = rtf3d_pkg::t_val'(1) << rtf3d_pkg::FB;
    localparam int IDLE_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    rtf3d_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    rtf3d_pkg::t_out o_data;

    rtf3d_pkg::t_val incr_m [9];
    rtf3d_pkg::t_val frame_m [9];
    bit clipped;
    rtf3d_pkg::t_out rotated_q [$];
    t_row rows [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;

    rotate_tensor_frame_3d dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_wide wv(rtf3d_pkg::t_val v);
        return t_wide'($signed(v));
    endfunction

    function automatic rtf3d_pkg::t_val clip(t_wide v);
        if (v > WMAX) begin
            clipped = 1'b1;
            return rtf3d_pkg::VAL_MAX;
        end
        if (v < WMIN) begin
            clipped = 1'b1;
            return rtf3d_pkg::VAL_MIN;
        end
        return v[rtf3d_pkg::VW-1:0];
    endfunction

    function automatic rtf3d_pkg::t_val qm(rtf3d_pkg::t_val a, rtf3d_pkg::t_val b);
        return clip((wv(a) * wv(b)) >>> rtf3d_pkg::FB);
    endfunction

    function automatic rtf3d_pkg::t_val qa(rtf3d_pkg::t_val a, rtf3d_pkg::t_val b);
        return clip(wv(a) + wv(b));
    endfunction

    function automatic rtf3d_pkg::t_val um(bit back, int i, int k);
        return back ? frame_m[3*k+i] : frame_m[3*i+k];
    endfunction

    function automatic void load_axes(rtf3d_pkg::t_in d);
        rtf3d_pkg::t_val v [6];
        rtf3d_pkg::t_val a [9];
        t_wide acc;
        v = '{d.value_0, d.value_1, d.value_2, d.value_3, d.value_4, d.value_5};
        for (int n = 0; n < 2; n++) begin
            for (int k = 0; k < 3; k++) begin
                acc = 0;
                for (int m = 0; m < 3; m++) acc += wv(qm(incr_m[3*m+k], v[3*n+m]));
                a[3*n+k] = clip(acc);
            end
        end
        a[6] = clip(wv(qm(a[1], a[5])) - wv(qm(a[4], a[2])));
        a[7] = clip(wv(qm(a[2], a[3])) - wv(qm(a[5], a[0])));
        a[8] = clip(wv(qm(a[0], a[4])) - wv(qm(a[3], a[1])));
        frame_m = a;
    endfunction

    function automatic rtf3d_pkg::t_out rotate(rtf3d_pkg::t_in d);
        rtf3d_pkg::t_val x [9];
        rtf3d_pkg::t_val y [9];
        rtf3d_pkg::t_val c;
        t_wide acc;
        bit back;
        bit strain;
        int i, j, k, l;
        rtf3d_pkg::t_out r;
        x = '{d.value_0, d.value_1, d.value_2, d.value_3, d.value_4,
              d.value_5, d.value_6, d.value_7, d.value_8};
        y = '{default: '0};
        clipped = 1'b0;
        back = d.mode inside {rtf3d_pkg::MODE_STRAIN_BACK, rtf3d_pkg::MODE_STRESS_BACK,
                              rtf3d_pkg::MODE_GRAD_BACK};
        strain = d.mode inside {rtf3d_pkg::MODE_STRAIN_FWD, rtf3d_pkg::MODE_STRAIN_BACK};
        if (d.mode inside {rtf3d_pkg::MODE_GRAD_FWD, rtf3d_pkg::MODE_GRAD_BACK}) begin
            for (int p = 0; p < 9; p++) begin
                i = p / 3;
                j = p % 3;
                acc = 0;
                for (int q = 0; q < 9; q++) begin
                    c = qm(um(back, i, q / 3), um(back, j, q % 3));
                    acc += wv(qm(c, x[q]));
                end
                y[p] = clip(acc);
            end
        end else begin
            for (int p = 0; p < 6; p++) begin
                i = rtf3d_pkg::VOIGT_I[p];
                j = rtf3d_pkg::VOIGT_J[p];
                acc = 0;
                for (int q = 0; q < 6; q++) begin
                    k = rtf3d_pkg::VOIGT_I[q];
                    l = rtf3d_pkg::VOIGT_J[q];
                    if (k == l) begin
                        c = qm(um(back, i, k), um(back, j, k));
                        if (strain && i != j) c = qa(c, c);
                    end else if (strain && i == j) begin
                        c = qm(um(back, i, k), um(back, i, l));
                    end else begin
                        c = qa(qm(um(back, i, k), um(back, j, l)),
                               qm(um(back, i, l), um(back, j, k)));
                    end
                    acc += wv(qm(c, x[q]));
                end
                y[p] = clip(acc);
            end
        end
        r = '{y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7], y[8], clipped};
        return r;
    endfunction

    function automatic rtf3d_pkg::t_in mk(logic [2:0] m, rtf3d_pkg::t_val a0,
                                          rtf3d_pkg::t_val a1, rtf3d_pkg::t_val a2,
                                          rtf3d_pkg::t_val a3, rtf3d_pkg::t_val a4,
                                          rtf3d_pkg::t_val a5, rtf3d_pkg::t_val a6 = '0,
                                          rtf3d_pkg::t_val a7 = '0,
                                          rtf3d_pkg::t_val a8 = '0);
        rtf3d_pkg::t_in d;
        d = '{m, a0, a1, a2, a3, a4, a5, a6, a7, a8};
        return d;
    endfunction

    // identity frame: result equals input, upper slots zero for symmetric modes
    function automatic rtf3d_pkg::t_out echo(rtf3d_pkg::t_in d);
        rtf3d_pkg::t_out r;
        bit sym;
        sym = d.mode < rtf3d_pkg::MODE_GRAD_FWD;
        r = '{d.value_0, d.value_1, d.value_2, d.value_3, d.value_4, d.value_5,
              sym ? '0 : d.value_6, sym ? '0 : d.value_7, sym ? '0 : d.value_8, 1'b0};
        return r;
    endfunction

    function automatic void add_row(rtf3d_pkg::t_in d, bit typed = 1'b0,
                                    rtf3d_pkg::t_out want = '0);
        t_row r;
        r.d = d;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    function automatic rtf3d_pkg::t_val rval(int spread);
        case ($urandom_range(spread, 0))
            0: return rtf3d_pkg::VAL_MAX;
            1: return rtf3d_pkg::VAL_MIN;
            2, 3: return rtf3d_pkg::t_val'({$urandom, $urandom});
            default: return rtf3d_pkg::t_val'($signed(t_wide'($urandom_range(2 * 4096, 0))
                                   - 4096) <<< (rtf3d_pkg::FB - 10));
        endcase
    endfunction

    function automatic rtf3d_pkg::t_val rcoef();
        if ($urandom_range(15, 0) == 0) return rtf3d_pkg::t_val'({$urandom, $urandom});
        return rtf3d_pkg::t_val'((t_wide'($urandom_range(2 * 65536, 0)) - 65536)
                                 <<< (rtf3d_pkg::FB - 16));
    endfunction

    task automatic report(string what, rtf3d_pkg::t_val got, rtf3d_pkg::t_val want);
        errors++;
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    task automatic send(rtf3d_pkg::t_in d, bit typed = 1'b0, rtf3d_pkg::t_out want = '0);
        while ($urandom_range(99, 0) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (d.mode == rtf3d_pkg::MODE_INC) begin
            for (int k = 0; k < 9; k++) incr_m[k] = d[rtf3d_pkg::VW*(8-k) +: rtf3d_pkg::VW];
        end else if (d.mode == rtf3d_pkg::MODE_AXES) begin
            load_axes(d);
        end else begin
            rotated_q.push_back(typed ? want : rotate(d));
        end
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99, 0) < recv_idle);
    end

    always @(posedge i_clk) begin
        rtf3d_pkg::t_val g [10];
        rtf3d_pkg::t_val w [10];
        rtf3d_pkg::t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotated_q.size() == 0) begin
                report("unexpected result item", o_data.result_0, '0);
            end else begin
                e = rotated_q.pop_front();
                g = '{o_data.result_0, o_data.result_1, o_data.result_2, o_data.result_3,
                      o_data.result_4, o_data.result_5, o_data.result_6, o_data.result_7,
                      o_data.result_8, rtf3d_pkg::t_val'(o_data.saturated)};
                w = '{e.result_0, e.result_1, e.result_2, e.result_3, e.result_4,
                      e.result_5, e.result_6, e.result_7, e.result_8,
                      rtf3d_pkg::t_val'(e.saturated)};
                for (int k = 0; k < 10; k++) begin
                    if (g[k] !== w[k])
                        report(k == 9 ? "saturated" : $sformatf("result_%0d", k), g[k], w[k]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        rtf3d_pkg::t_in d;
        int phase_len;
        incr_m = '{default: '0};
        frame_m = '{default: '0};

        // no frame yet: everything rotates to zero
        add_row(mk(rtf3d_pkg::MODE_STRAIN_FWD, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
                   rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
                   rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
                   rtf3d_pkg::VAL_MAX), 1'b1, '0);
        add_row(mk(rtf3d_pkg::MODE_STRESS_FWD, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX,
                   rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN,
                   rtf3d_pkg::VAL_MAX), 1'b1, '0);
        add_row(mk(rtf3d_pkg::MODE_GRAD_BACK, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
                   rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
                   rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
                   rtf3d_pkg::VAL_MIN), 1'b1, '0);
        // identity frame
        add_row(mk(rtf3d_pkg::MODE_INC, ONE, '0, '0, '0, ONE, '0, '0, '0, ONE));
        add_row(mk(rtf3d_pkg::MODE_AXES, ONE, '0, '0, '0, ONE, '0, rtf3d_pkg::VAL_MAX,
                   rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX));
        d = mk(rtf3d_pkg::MODE_STRAIN_FWD, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX);
        add_row(d, 1'b1, echo(d));
        d = mk(rtf3d_pkg::MODE_STRAIN_BACK, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
               rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
               rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MIN,
               rtf3d_pkg::VAL_MIN);
        add_row(d, 1'b1, echo(d));
        d = mk(rtf3d_pkg::MODE_STRESS_FWD, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN, ONE,
               -ONE, '0, 48'h1, rtf3d_pkg::VAL_MIN, '0, ONE);
        add_row(d, 1'b1, echo(d));
        d = mk(rtf3d_pkg::MODE_STRESS_BACK, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX, '1,
               ONE, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN);
        add_row(d, 1'b1, echo(d));
        d = mk(rtf3d_pkg::MODE_GRAD_FWD, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MAX);
        add_row(d, 1'b1, echo(d));
        d = mk(rtf3d_pkg::MODE_GRAD_BACK, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN,
               rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX,
               rtf3d_pkg::VAL_MIN);
        add_row(d, 1'b1, echo(d));
        // doubled frame: saturation
        add_row(mk(rtf3d_pkg::MODE_INC, ONE << 1, '0, '0, '0, ONE << 1, '0, '0, '0,
                   ONE << 1));
        add_row(mk(rtf3d_pkg::MODE_AXES, ONE, '0, '0, '0, ONE, '0));
        for (int m = rtf3d_pkg::MODE_STRAIN_FWD; m <= rtf3d_pkg::MODE_GRAD_BACK; m++)
            add_row(mk(3'(m), rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX,
                       rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN,
                       rtf3d_pkg::VAL_MAX, rtf3d_pkg::VAL_MIN, rtf3d_pkg::VAL_MAX));
        // quarter turn about z
        add_row(mk(rtf3d_pkg::MODE_INC, '0, ONE, '0, -ONE, '0, '0, '0, '0, ONE));
        add_row(mk(rtf3d_pkg::MODE_AXES, ONE, '0, '0, '0, ONE, '0));
        for (int m = rtf3d_pkg::MODE_STRAIN_FWD; m <= rtf3d_pkg::MODE_GRAD_BACK; m++)
            add_row(mk(3'(m), ONE, ONE << 1, ONE << 2, ONE >> 1, ONE >> 2, -ONE,
                       ONE << 3, -ONE << 1, ONE >> 3));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send(rows[n].d, rows[n].typed, rows[n].want);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 36 : 0;
            phase_len = 0;
            while (phase_len < 330) begin
                if ($urandom_range(29, 0) == 0) begin
                    send(mk(rtf3d_pkg::MODE_INC, rcoef(), rcoef(), rcoef(), rcoef(), rcoef(),
                            rcoef(), rcoef(), rcoef(), rcoef()));
                    send(mk(rtf3d_pkg::MODE_AXES, rcoef(), rcoef(), rcoef(), rcoef(), rcoef(),
                            rcoef(), rval(9), rval(9), rval(9)));
                end else begin
                    send(mk(3'($urandom_range(rtf3d_pkg::MODE_GRAD_BACK,
                                              rtf3d_pkg::MODE_STRAIN_FWD)), rval(9),
                            rval(9), rval(9), rval(9), rval(9), rval(9), rval(9), rval(9),
                            rval(9)));
                    phase_len++;
                end
            end
        end
        i_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/rtf3d_pkg.sv
sv/rotate_tensor_frame_3d.sv
sim/rotate_tensor_frame_3d_tb.sv
